>>> sv/mi3_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants, cofactor index tables and pipeline control type for the
// 3x3 matrix inverse core.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int unsigned ENTRY_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned N_ENT           = 9;
  localparam int unsigned N_ROW           = 3;

  // cofactor k = a[CF_PA[k]] * a[CF_PB[k]] - a[CF_QA[k]] * a[CF_QB[k]]
  localparam int unsigned CF_PA [N_ENT] = '{4, 2, 1, 6, 0, 2, 3, 6, 0};
  localparam int unsigned CF_PB [N_ENT] = '{8, 7, 5, 5, 8, 3, 7, 1, 4};
  localparam int unsigned CF_QA [N_ENT] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
  localparam int unsigned CF_QB [N_ENT] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

  // determinant expansion along row 1 uses these cofactors
  localparam int unsigned DET_CSEL [N_ROW] = '{0, 3, 6};

  typedef struct packed {
    logic en;
    logic vld;
  } mi3_ctl_t;

endpackage
`default_nettype wire

>>> sv/mat3_inverse_with_determinant_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mat3_inverse_with_determinant_core
// 3x3 inverse by adjugate with determinant, signed fixed point, pipelined.
//
// channel  dir  payload
// s_*      in   tdata: m11 m12 m13 m21 m22 m23 m31 m32 m33
// m_*      out  tdata: inv11..inv33, determinant; tuser: singular
//
// One item per cycle while the output is not stalled; the divider
// has one stage per quotient bit.
// rst is synchronous and clears the valid bits only.
// A stall at the output freezes the whole pipe; s_tready follows it.
// ----------------------------------------------------------------------------
module mat3_inverse_with_determinant_core
  import mi3_pkg::*;
#(
  parameter int unsigned ENTRY_WIDTH = ENTRY_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // m11, m12, m13, m21, m22, m23, m31, m32, m33
  input  logic [((9*ENTRY_WIDTH+7)/8)*8-1:0]       s_tdata,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // inv11, inv12, inv13, inv21, inv22, inv23, inv31, inv32, inv33, determinant
  output logic [((10*ENTRY_WIDTH+7)/8)*8-1:0]      m_tdata,
  // singular
  output logic [0:0]                               m_tuser
);

  localparam int unsigned W   = ENTRY_WIDTH;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned CW  = 2 * W + 1;
  localparam int unsigned DW  = 3 * W + 3;
  localparam int unsigned AW  = DW;
  localparam int unsigned LAT = W + 2;
  localparam int unsigned OTW = ((10 * W + 7) / 8) * 8;
  localparam logic signed [W-1:0] QMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] QMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [AW-1:0] DLIM = AW'(1) << (W - 1);

  logic                en;
  mi3_ctl_t            ctl;
  logic signed [W-1:0] a     [N_ENT];
  logic                cf_vld;
  logic signed [CW-1:0] cf_c [N_ENT];
  logic signed [W-1:0] cf_row [N_ROW];
  mi3_ctl_t            det_ctl;
  logic                dt_vld;
  logic signed [CW-1:0] dt_c [N_ENT];
  logic signed [DW-1:0] dt_d;

  logic                v6;
  logic signed [CW-1:0] c6 [N_ENT];
  logic [AW-1:0]       absd6;
  logic                dneg6;
  logic                zero6;

  logic [AW-1:0]       dshift;
  logic signed [W-1:0] det_next;
  logic signed [W-1:0] dly_det  [LAT];
  logic                dly_zero [LAT];
  logic                dly_v    [LAT];
  logic signed [W-1:0] inv      [N_ENT];
  logic [10*W-1:0]     out_pack;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign ctl      = '{en: en, vld: s_tvalid};
  assign det_ctl  = '{en: en, vld: cf_vld};

  always_comb begin
    for (int k = 0; k < N_ENT; k++) begin
      a[k] = $signed(s_tdata[k*W +: W]);
    end
  end

  mi3_cofactor #(.W(W)) u_cof (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .a   (a),
    .vld (cf_vld),
    .c   (cf_c),
    .row (cf_row)
  );

  mi3_det #(.W(W)) u_det (
    .clk   (clk),
    .rst   (rst),
    .ctl   (det_ctl),
    .c_in  (cf_c),
    .row   (cf_row),
    .vld   (dt_vld),
    .c_out (dt_c),
    .d     (dt_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= dt_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c6    <= dt_c;
      dneg6 <= dt_d[DW-1];
      absd6 <= dt_d[DW-1] ? AW'(-dt_d) : AW'(dt_d);
      zero6 <= dt_d == '0;
    end
  end

  always_comb begin
    dshift = absd6 >> (2 * F);
    if (dneg6) begin
      det_next = (dshift > DLIM) ? QMIN : -$signed(dshift[W-1:0]);
    end else begin
      det_next = (dshift >= DLIM) ? QMAX : $signed(dshift[W-1:0]);
    end
  end

  for (genvar k = 0; k < N_ENT; k++) begin : g_div
    mi3_div #(.W(W), .F(F)) u_div (
      .clk  (clk),
      .en   (en),
      .c    (c6[k]),
      .absd (absd6),
      .dneg (dneg6),
      .zero (zero6),
      .q    (inv[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < LAT; s++) begin
        dly_v[s] <= 1'b0;
      end
    end else if (en) begin
      dly_v[0] <= v6;
      for (int s = 1; s < LAT; s++) begin
        dly_v[s] <= dly_v[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dly_det[0]  <= det_next;
      dly_zero[0] <= zero6;
      for (int s = 1; s < LAT; s++) begin
        dly_det[s]  <= dly_det[s-1];
        dly_zero[s] <= dly_zero[s-1];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < N_ENT; k++) begin
      out_pack[k*W +: W] = inv[k];
    end
    out_pack[N_ENT*W +: W] = dly_det[LAT-1];
  end

  assign m_tvalid   = dly_v[LAT-1];
  assign m_tdata    = OTW'(out_pack);
  assign m_tuser[0] = dly_zero[LAT-1];

  a_sing_inv_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> out_pack[N_ENT*W-1:0] == '0)
    else $error("singular item with nonzero inverse");

  a_sing_det_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> dly_det[LAT-1] == '0)
    else $error("singular item with nonzero determinant");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v6) && $stable(dly_v[0]) && $stable(m_tuser))
    else $error("pipe moved during stall");

endmodule
`default_nettype wire

>>> sv/mi3_cofactor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_cofactor
// Two stages: the eighteen entry products, then the nine cofactors.
// ----------------------------------------------------------------------------
module mi3_cofactor
  import mi3_pkg::*;
#(
  parameter int unsigned W = ENTRY_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  mi3_ctl_t            ctl,
  input  logic signed [W-1:0] a   [N_ENT],
  output logic                vld,
  output logic signed [2*W:0] c   [N_ENT],
  output logic signed [W-1:0] row [N_ROW]
);

  localparam int unsigned PW = 2 * W;
  localparam int unsigned CW = 2 * W + 1;

  logic signed [PW-1:0] prod_p [N_ENT];
  logic signed [PW-1:0] prod_q [N_ENT];
  logic signed [W-1:0]  row1   [N_ROW];
  logic                 v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      vld <= 1'b0;
    end else if (ctl.en) begin
      v1  <= ctl.vld;
      vld <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int k = 0; k < N_ENT; k++) begin
        prod_p[k] <= a[CF_PA[k]] * a[CF_PB[k]];
        prod_q[k] <= a[CF_QA[k]] * a[CF_QB[k]];
        c[k]      <= CW'(prod_p[k]) - CW'(prod_q[k]);
      end
      for (int r = 0; r < N_ROW; r++) begin
        row1[r] <= a[r];
        row[r]  <= row1[r];
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/mi3_det.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_det
// Three stages: split partial products of row 1 by its cofactors, the three
// terms, their sum. Cofactors travel alongside.
// ----------------------------------------------------------------------------
module mi3_det
  import mi3_pkg::*;
#(
  parameter int unsigned W = ENTRY_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mi3_ctl_t              ctl,
  input  logic signed [2*W:0]   c_in  [N_ENT],
  input  logic signed [W-1:0]   row   [N_ROW],
  output logic                  vld,
  output logic signed [2*W:0]   c_out [N_ENT],
  output logic signed [3*W+2:0] d
);

  localparam int unsigned CW  = 2 * W + 1;
  localparam int unsigned PPW = 2 * W + 1;
  localparam int unsigned DW  = 3 * W + 3;

  logic signed [PPW-1:0] pp_lo [N_ROW];
  logic signed [PPW-1:0] pp_hi [N_ROW];
  logic signed [DW-1:0]  term  [N_ROW];
  logic signed [CW-1:0]  c3    [N_ENT];
  logic signed [CW-1:0]  c4    [N_ENT];
  logic                  v3;
  logic                  v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3  <= 1'b0;
      v4  <= 1'b0;
      vld <= 1'b0;
    end else if (ctl.en) begin
      v3  <= ctl.vld;
      v4  <= v3;
      vld <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int r = 0; r < N_ROW; r++) begin
        pp_lo[r] <= row[r] * $signed({1'b0, c_in[DET_CSEL[r]][W-1:0]});
        pp_hi[r] <= row[r] * $signed(c_in[DET_CSEL[r]][CW-1:W]);
        term[r]  <= (DW'(pp_hi[r]) <<< W) + DW'(pp_lo[r]);
      end
      d <= term[0] + term[1] + term[2];
      for (int k = 0; k < N_ENT; k++) begin
        c3[k]    <= c_in[k];
        c4[k]    <= c3[k];
        c_out[k] <= c4[k];
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/mi3_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_div
// Pipelined restoring divider: one prepare stage, one stage per quotient
// bit, one saturation stage.
// ----------------------------------------------------------------------------
module mi3_div
  import mi3_pkg::*;
#(
  parameter int unsigned W = ENTRY_WIDTH_DEF,
  parameter int unsigned F = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [2*W:0]  c,
  input  logic        [3*W+2:0] absd,
  input  logic                 dneg,
  input  logic                 zero,
  output logic signed [W-1:0]  q
);

  localparam int unsigned CW = 2 * W + 1;
  localparam int unsigned AW = 3 * W + 3;
  localparam int unsigned NW = CW + 2 * F;
  localparam int unsigned XW = ((NW > AW) ? NW : AW) + 1;
  localparam logic signed [W-1:0] QMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] QMIN = {1'b1, {(W-1){1'b0}}};

  logic [CW-1:0] cmag;
  logic [NW-1:0] nmag;
  logic [XW-1:0] nhi;

  logic [AW-1:0] rem [W+1];
  logic [W-1:0]  nlo [W+1];
  logic [W-1:0]  qb  [W+1];
  logic [AW-1:0] dd  [W+1];
  logic          sg  [W+1];
  logic          ov  [W+1];
  logic          zz  [W+1];

  always_comb begin
    cmag = c[CW-1] ? CW'(-c) : CW'(c);
    nmag = NW'(cmag) << (2 * F);
    nhi  = XW'(nmag >> W);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= nhi[AW-1:0];
      nlo[0] <= nmag[W-1:0];
      qb[0]  <= '0;
      dd[0]  <= absd;
      sg[0]  <= c[CW-1] ^ dneg;
      ov[0]  <= nhi >= XW'(absd);
      zz[0]  <= zero;
    end
  end

  for (genvar s = 1; s <= W; s++) begin : g_stage
    logic [AW:0] trial;
    logic        ge;
    always_comb begin
      trial = {rem[s-1], nlo[s-1][W-1]};
      ge    = trial >= {1'b0, dd[s-1]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= ge ? AW'(trial - {1'b0, dd[s-1]}) : trial[AW-1:0];
        nlo[s] <= nlo[s-1] << 1;
        qb[s]  <= {qb[s-1][W-2:0], ge};
        dd[s]  <= dd[s-1];
        sg[s]  <= sg[s-1];
        ov[s]  <= ov[s-1];
        zz[s]  <= zz[s-1];
      end
    end
  end

  logic pos_sat;
  logic neg_sat;

  always_comb begin
    pos_sat = ov[W] || qb[W][W-1];
    neg_sat = ov[W] || (qb[W][W-1] && (|qb[W][W-2:0]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zz[W]) begin
        q <= '0;
      end else if (sg[W]) begin
        q <= neg_sat ? QMIN : -$signed(qb[W]);
      end else begin
        q <= pos_sat ? QMAX : $signed(qb[W]);
      end
    end
  end

endmodule
`default_nettype wire
